FILE: rtl/ssg_pkg.sv
// Shared types and constants for the shutter sub-sample generator.
// Used by ssg_regs, ssg_ctrl, ssg_dp and the top level; depends on nothing.
`default_nettype none

package ssg_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int TIME_W    = 48;
  localparam int WEIGHT_W  = 17;
  localparam int INDEX_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int SEED_W    = 64;
  localparam int EXP_W     = 32;
  localparam int PHASE_W   = 32;
  localparam int JIT_W     = 30;
  localparam int JIT_LSB   = 33;
  localparam int DEN_W     = COUNT_W + JIT_W;
  localparam int BOX_NUM_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE    = 3'd6;

  localparam logic [1:0] PAT_UNIFORM = 2'd0;
  localparam logic [1:0] PAT_STRAT   = 2'd1;
  localparam logic [1:0] PAT_HALTON  = 2'd2;

  localparam logic [1:0] FILT_BOX   = 2'd0;
  localparam logic [1:0] FILT_TRI   = 2'd1;
  localparam logic [1:0] FILT_GAUSS = 2'd2;

  localparam logic [SEED_W-1:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [SEED_W-1:0] LCG_ADD = 64'd1442695040888963407;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [WEIGHT_W-1:0] HALF_Q16   = 17'h08000;

  localparam logic [TIME_W-1:0] TIME_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0] TIME_MIN = 48'h8000_0000_0000;

  // round(65536 * exp(-2 * (k/32)^2)), k = 0..32
  localparam logic [WEIGHT_W-1:0] GAUSS_TAB [33] = '{
    17'd65536, 17'd65408, 17'd65026, 17'd64394, 17'd63520, 17'd62413, 17'd61086,
    17'd59555, 17'd57835, 17'd55947, 17'd53908, 17'd51742, 17'd49469, 17'd47112,
    17'd44692, 17'd42231, 17'd39750, 17'd37268, 17'd34806, 17'd32379, 17'd30005,
    17'd27696, 17'd25465, 17'd23322, 17'd21276, 17'd19335, 17'd17502, 17'd15780,
    17'd14173, 17'd12680, 17'd11300, 17'd10031, 17'd8869
  };

  typedef struct packed {
    logic                      enable;
    logic [COUNT_W-1:0]        sample_count;
    logic [1:0]                pattern_mode;
    logic [1:0]                filter_mode;
    logic [SEED_W-1:0]         lcg_seed;
    logic [EXP_W-1:0]          exposure_len;
    logic signed [PHASE_W-1:0] phase_offset;
    logic [COUNT_W-1:0]        n_eff;
    logic                      single;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_BOX,
    DIV_UNI,
    DIV_STRAT
  } div_mode_t;

  typedef enum logic [1:0] {
    LCG_P0,
    LCG_P1,
    LCG_P2,
    LCG_P3
  } lcg_phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SINGLE,
    S_BOX,
    S_BOXW,
    S_START,
    S_L0,
    S_L1,
    S_L2,
    S_L3,
    S_DIVS,
    S_DIVW,
    S_OFS,
    S_MUL,
    S_RND,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       frame_load;
    logic       div_load;
    div_mode_t  div_mode;
    logic       lcg_go;
    lcg_phase_t lcg_phase;
    logic       box_store;
    logic       ofs_load;
    logic       mul_load;
    logic       rnd_load;
    logic       out_single;
    logic       out_sample;
    logic       idx_inc;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic last;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/ssg_regs.sv
// Configuration register file with derived sample count and single-sample flag.
// Depends on ssg_pkg.
`default_nettype none

module ssg_regs
  import ssg_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  logic                enable;
  logic [COUNT_W-1:0]  sample_count;
  logic [1:0]          pattern_mode;
  logic [1:0]          filter_mode;
  logic [SEED_W-1:0]   lcg_seed;
  logic [EXP_W-1:0]    exposure_len;
  logic [PHASE_W-1:0]  phase_offset;

  localparam logic [COUNT_W-1:0] N_MAX = COUNT_W'(MAX_SAMPLES);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      sample_count <= 7'd8;
      pattern_mode <= PAT_UNIFORM;
      filter_mode  <= FILT_BOX;
      lcg_seed     <= '0;
      exposure_len <= 32'h0080_0000;
      phase_offset <= 32'hFFC0_0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:   enable       <= cfg_data[0];
        REG_COUNT:    sample_count <= cfg_data[COUNT_W-1:0];
        REG_PATTERN:  pattern_mode <= cfg_data[1:0];
        REG_FILTER:   filter_mode  <= cfg_data[1:0];
        REG_SEED:     lcg_seed     <= cfg_data;
        REG_EXPOSURE: exposure_len <= cfg_data[EXP_W-1:0];
        REG_PHASE:    phase_offset <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.enable       = enable;
    cfg.sample_count = sample_count;
    cfg.pattern_mode = pattern_mode;
    cfg.filter_mode  = filter_mode;
    cfg.lcg_seed     = lcg_seed;
    cfg.exposure_len = exposure_len;
    cfg.phase_offset = phase_offset;
    cfg.n_eff        = (sample_count > N_MAX) ? N_MAX : sample_count;
    cfg.single       = !enable || (sample_count <= 7'd1);
  end

endmodule

`default_nettype wire

FILE: rtl/ssg_ctrl.sv
// Sequencer: walks each frame through the LCG, divide, offset, multiply, round and emit steps its mode uses.
// Depends on ssg_pkg; drives ssg_dp through cmd_t and reads status_t.
`default_nettype none

module ssg_ctrl
  import ssg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   box_filter;

  assign box_filter = (cfg.filter_mode != FILT_TRI) && (cfg.filter_mode != FILT_GAUSS);
  assign in_ready   = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.div_mode = DIV_UNI;
    cmd.lcg_phase = LCG_P0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.frame_load = 1'b1;
          if (cfg.single) state_next = S_SINGLE;
          else if (box_filter) state_next = S_BOX;
          else state_next = S_START;
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.out_single = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_BOX: begin
        cmd.div_load = 1'b1;
        cmd.div_mode = DIV_BOX;
        state_next   = S_BOXW;
      end
      S_BOXW: begin
        if (!stat.div_busy) begin
          cmd.box_store = 1'b1;
          state_next    = S_START;
        end
      end
      S_START: begin
        if (cfg.pattern_mode == PAT_STRAT) begin
          state_next = S_L0;
        end else if (cfg.pattern_mode == PAT_HALTON) begin
          state_next = S_OFS;
        end else begin
          cmd.div_load = 1'b1;
          cmd.div_mode = DIV_UNI;
          state_next   = S_DIVW;
        end
      end
      S_L0: begin
        cmd.lcg_go    = 1'b1;
        cmd.lcg_phase = LCG_P0;
        state_next    = S_L1;
      end
      S_L1: begin
        cmd.lcg_go    = 1'b1;
        cmd.lcg_phase = LCG_P1;
        state_next    = S_L2;
      end
      S_L2: begin
        cmd.lcg_go    = 1'b1;
        cmd.lcg_phase = LCG_P2;
        state_next    = S_L3;
      end
      S_L3: begin
        cmd.lcg_go    = 1'b1;
        cmd.lcg_phase = LCG_P3;
        state_next    = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_load = 1'b1;
        cmd.div_mode = DIV_STRAT;
        state_next   = S_DIVW;
      end
      S_DIVW: begin
        if (!stat.div_busy) state_next = S_OFS;
      end
      S_OFS: begin
        cmd.ofs_load = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_RND;
      end
      S_RND: begin
        cmd.rnd_load = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_sample = 1'b1;
          if (stat.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_START;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ssg_dp.sv
// Datapath: LCG, shared restoring divider, Halton mirror, weights, time sum, output word.
// Depends on ssg_pkg; controlled by ssg_ctrl through cmd_t.
`default_nettype none

module ssg_dp
  import ssg_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  cmd_t                cmd,
  output status_t             stat,
  input  logic [TIME_W-1:0]   frame_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TIME_W-1:0]   sample_time,
  output logic [WEIGHT_W-1:0] weight,
  output logic [INDEX_W-1:0]  sample_index,
  output logic                last
);

  localparam int IW  = $clog2(MAX_SAMPLES);
  localparam int OW  = FRAC_BITS + 1;
  localparam int PW  = OW + EXP_W;
  localparam int DLW = PW + 1 - (FRAC_BITS + 8);
  localparam int QW  = (OW > BOX_NUM_W + 1) ? OW : BOX_NUM_W + 1;
  localparam int RW  = DEN_W + 1;
  localparam int CW  = $clog2(QW + 1);
  localparam int SUM_W = TIME_W + 2;

  localparam logic [OW-1:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW:0]   ROUND = {{PW{1'b0}}, 1'b1} << (FRAC_BITS + 7);

  logic [IW-1:0]      idx;
  logic [TIME_W-1:0]  frame_q;
  logic [TIME_W:0]    base;
  logic [SEED_W-1:0]  lcg;
  logic [SEED_W-1:0]  lcg_prod;
  logic [SEED_W-1:0]  lcg_acc;
  logic [DEN_W-1:0]   div_rem;
  logic [DEN_W-1:0]   div_den;
  logic [QW-1:0]      div_quo;
  logic [BOX_NUM_W-1:0] div_bits;
  logic [CW-1:0]      div_cnt;
  logic               div_first;
  logic [WEIGHT_W-1:0] box_w;
  logic [OW-1:0]      ofs;
  logic [PW-1:0]      prod;
  logic [WEIGHT_W-1:0] wgt;
  logic [DLW-1:0]     delta;

  // LCG multiply, one 32x32 partial product in each of phases P0 to P2
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;

  assign mul_a = (cmd.lcg_phase == LCG_P1) ? lcg[63:32] : lcg[31:0];
  assign mul_b = (cmd.lcg_phase == LCG_P2) ? LCG_MUL[63:32] : LCG_MUL[31:0];
  assign mul_p = mul_a * mul_b;

  // divider operands
  logic [DEN_W-1:0]     idx_ext;
  logic [DEN_W-1:0]     n_ext;
  logic [DEN_W-1:0]     strat_num;
  logic [DEN_W-1:0]     strat_den;
  logic [DEN_W-1:0]     uni_num;
  logic [DEN_W-1:0]     uni_den;
  logic [BOX_NUM_W-1:0] box_num;

  assign idx_ext   = DEN_W'(idx);
  assign n_ext     = DEN_W'(cfg.n_eff);
  assign strat_num = (idx_ext << JIT_W) - idx_ext + DEN_W'(lcg[JIT_LSB +: JIT_W]);
  assign strat_den = (n_ext << JIT_W) - n_ext;
  assign uni_num   = DEN_W'({idx, 1'b1});
  assign uni_den   = DEN_W'({cfg.n_eff, 1'b0});
  assign box_num   = WEIGHT_ONE + BOX_NUM_W'(cfg.n_eff[COUNT_W-1:1]);

  logic [RW-1:0]    div_cur;
  logic [RW-1:0]    div_diff;
  logic             div_ge;

  assign div_cur  = div_first ? {1'b0, div_rem} : {div_rem, div_bits[BOX_NUM_W-1]};
  assign div_diff = div_cur - {1'b0, div_den};
  assign div_ge   = (div_cur >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= (cmd.div_mode == DIV_BOX) ? CW'(BOX_NUM_W + 1) : CW'(FRAC_BITS + 1);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_first <= 1'b1;
      div_quo   <= '0;
      case (cmd.div_mode)
        DIV_BOX: begin
          div_rem  <= '0;
          div_den  <= n_ext;
          div_bits <= box_num;
        end
        DIV_STRAT: begin
          div_rem  <= strat_num;
          div_den  <= strat_den;
          div_bits <= '0;
        end
        default: begin
          div_rem  <= uni_num;
          div_den  <= uni_den;
          div_bits <= '0;
        end
      endcase
    end else if (div_cnt != '0) begin
      div_first <= 1'b0;
      div_rem   <= div_ge ? div_diff[DEN_W-1:0] : div_cur[DEN_W-1:0];
      div_quo   <= {div_quo[QW-2:0], div_ge};
      if (!div_first) div_bits <= {div_bits[BOX_NUM_W-2:0], 1'b0};
    end
  end

  // LCG state
  always_ff @(posedge clk) begin
    if (cmd.frame_load) begin
      lcg <= cfg.lcg_seed;
    end else if (cmd.lcg_go) begin
      case (cmd.lcg_phase)
        LCG_P0: lcg_prod <= mul_p;
        LCG_P1: begin
          lcg_acc  <= lcg_prod + LCG_ADD;
          lcg_prod <= mul_p;
        end
        LCG_P2: begin
          lcg_acc[63:32] <= lcg_acc[63:32] + lcg_prod[31:0];
          lcg_prod       <= mul_p;
        end
        default: lcg <= {lcg_acc[63:32] + lcg_prod[31:0], lcg_acc[31:0]};
      endcase
    end
  end

  // Halton base 2: bits of i+1 mirrored about the binary point
  logic [COUNT_W-1:0] hal_v;
  logic [OW-1:0]      halton;

  assign hal_v = COUNT_W'(idx) + COUNT_W'(1);

  always_comb begin
    halton = '0;
    for (int p = 0; p < COUNT_W; p++) begin
      halton[FRAC_BITS-1-p] = hal_v[p];
    end
  end

  // filter weight from the offset
  logic [OW-1:0]       t_cl;
  logic [OW+15:0]      t_wide;
  logic [WEIGHT_W-1:0] t16;
  logic [WEIGHT_W-1:0] d_half;
  logic [WEIGHT_W-1:0] d17;
  logic [5:0]          g_lo;
  logic [5:0]          g_hi;
  logic [10:0]         g_frac;
  logic [WEIGHT_W-1:0] g_a;
  logic [WEIGHT_W-1:0] g_b;
  logic [WEIGHT_W-1:0] g_diff;
  logic [27:0]         g_mul;
  logic [27:0]         g_rnd;
  logic [WEIGHT_W-1:0] g_w;
  logic [WEIGHT_W-1:0] weight_c;

  always_comb begin
    if (cfg.exposure_len == '0) t_cl = '0;
    else if (ofs > ONE_F) t_cl = ONE_F;
    else t_cl = ofs;
    t_wide = {t_cl, 16'b0} >> FRAC_BITS;
    t16    = t_wide[WEIGHT_W-1:0];
    d_half = (t16 >= HALF_Q16) ? (t16 - HALF_Q16) : (HALF_Q16 - t16);
    d17    = {d_half[15:0], 1'b0};
    g_lo   = {1'b0, d17[15:11]};
    g_hi   = g_lo + 6'd1;
    g_frac = d17[10:0];
    g_a    = GAUSS_TAB[g_lo];
    g_b    = GAUSS_TAB[g_hi];
    g_diff = g_a - g_b;
    g_mul  = g_diff * g_frac;
    g_rnd  = g_mul + 28'd1024;
    g_w    = d17[16] ? GAUSS_TAB[32] : (g_a - g_rnd[27:11]);
    case (cfg.filter_mode)
      FILT_TRI:   weight_c = WEIGHT_ONE - d17;
      FILT_GAUSS: weight_c = g_w;
      default:    weight_c = box_w;
    endcase
  end

  // per-frame and per-sample registers
  logic [PW:0] rnd_sum;
  assign rnd_sum = {1'b0, prod} + ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.frame_load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_load) begin
      frame_q <= frame_time;
      base    <= {frame_time[TIME_W-1], frame_time}
               + {{(TIME_W + 1 - 24){cfg.phase_offset[PHASE_W-1]}}, cfg.phase_offset[31:8]};
    end
    if (cmd.box_store) box_w <= div_quo[WEIGHT_W-1:0];
    if (cmd.ofs_load) ofs <= (cfg.pattern_mode == PAT_HALTON) ? halton : div_quo[OW-1:0];
    if (cmd.mul_load) begin
      prod <= ofs * cfg.exposure_len;
      wgt  <= weight_c;
    end
    if (cmd.rnd_load) delta <= rnd_sum[PW:FRAC_BITS+8];
  end

  // sum and saturate
  logic [SUM_W-1:0]  t_sum;
  logic [TIME_W-1:0] t_sat;
  logic              last_c;

  assign t_sum  = {base[TIME_W], base} + {{(SUM_W - DLW){1'b0}}, delta};
  assign last_c = (COUNT_W'(idx) + COUNT_W'(1)) == cfg.n_eff;

  always_comb begin
    if (t_sum[SUM_W-1:TIME_W-1] == 3'b000 || t_sum[SUM_W-1:TIME_W-1] == 3'b111) begin
      t_sat = t_sum[TIME_W-1:0];
    end else if (t_sum[SUM_W-1]) begin
      t_sat = TIME_MIN;
    end else begin
      t_sat = TIME_MAX;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_single || cmd.out_sample) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_single) begin
      sample_time  <= frame_q;
      weight       <= WEIGHT_ONE;
      sample_index <= '0;
      last         <= 1'b1;
    end else if (cmd.out_sample) begin
      sample_time  <= t_sat;
      weight       <= wgt;
      sample_index <= INDEX_W'(idx);
      last         <= last_c;
    end
  end

  assign stat.div_busy = (div_cnt != '0);
  assign stat.out_free = !out_valid || out_ready;
  assign stat.last     = last_c;

endmodule

`default_nettype wire

FILE: rtl/shutter_subsample_generator.sv
// Top level of the shutter sub-sample generator: config registers, sequencer, datapath.
// Depends on ssg_pkg, ssg_regs, ssg_ctrl and ssg_dp.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   frame_time
//   out      source     out_valid / out_ready sample_time, weight, sample_index, last
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Sub-sample pacing is set by the bit-per-cycle restoring divider (uniform, stratified)
// and the four-phase 32x32 LCG multiply (stratified); Halton uses neither.
// Box filter adds a 1/n divide per frame; a single-sample frame goes straight to output.
// One frame is in work at a time; in_ready is high only between frames.
// A finished word waits in the output register; the sequencer stalls until it is taken.
// Synchronous reset clears the sequencer, counters and output valid, and sets config registers to defaults.
`default_nettype none

module shutter_subsample_generator
  import ssg_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TIME_W-1:0]    frame_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TIME_W-1:0]    sample_time,
  output logic [WEIGHT_W-1:0]  weight,
  output logic [INDEX_W-1:0]   sample_index,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t stat;

  ssg_regs #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssg_dp #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .frame_time   (frame_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_time  (sample_time),
    .weight       (weight),
    .sample_index (sample_index),
    .last         (last)
  );

  a_mid_frame_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |-> !in_ready)
    else $error("frame accepted before its last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_single || cmd.out_sample) |-> (!out_valid || out_ready))
    else $error("output word overwritten");

  a_div_reload: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |-> !stat.div_busy)
    else $error("divider reloaded while busy");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready after frame accept");

endmodule

`default_nettype wire
